// ===== rtl/utf8x_pkg.sv =====
// shared types and constants for the extended utf-8 stream decoder
// no dependencies; the other rtl files refer to this package by scoped names, the bench imports it
`timescale 1ns / 1ps

package utf8x_pkg;

	localparam int LENGTH_BITS    = 16;
	localparam int COUNT_BITS     = 16;
	localparam int CP_BITS        = 32;
	localparam int ACC_BITS       = 36;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		STATUS_OK         = 4'd0,
		STATUS_BAD_LEAD   = 4'd1,
		STATUS_INCOMPLETE = 4'd2,
		STATUS_BAD_CONT   = 4'd3,
		STATUS_OVERLONG   = 4'd4,
		STATUS_RANGE      = 4'd5,
		STATUS_SURROGATE  = 4'd6,
		STATUS_FFFE       = 4'd7,
		STATUS_FFFF       = 4'd8,
		STATUS_HIGH       = 4'd9
	} status_t;

	// one classified input beat as it travels from front to back
	typedef struct packed {
		logic       last;
		logic       is_cont;
		logic [5:0] payload;
		logic       bad_lead;
		logic       incomplete;
		logic [2:0] extra;
		logic [6:0] init;
	} cls_t;

	// smallest value that a form of the given byte length may carry
	function automatic logic [ACC_BITS-1:0] min_for_length(input logic [2:0] len);
		logic [ACC_BITS-1:0] m;
		begin
			case (len)
				3'd2:    m = ACC_BITS'(36'h0_0000_0080);
				3'd3:    m = ACC_BITS'(36'h0_0000_0800);
				3'd4:    m = ACC_BITS'(36'h0_0001_0000);
				3'd5:    m = ACC_BITS'(36'h0_0020_0000);
				3'd6:    m = ACC_BITS'(36'h0_0400_0000);
				3'd7:    m = ACC_BITS'(36'h0_8000_0000);
				default: m = '0;
			endcase
			return m;
		end
	endfunction

endpackage

// ===== rtl/utf8x_in_if.sv =====
// input channel: one raw byte with the count of bytes left in its string
// depends on utf8x_pkg
`timescale 1ns / 1ps

interface utf8x_in_if;
	logic                              valid;
	logic                              ready;
	logic [7:0]                        data_byte;
	logic [utf8x_pkg::LENGTH_BITS-1:0] bytes_left;

	modport source (output valid, output data_byte, output bytes_left, input ready);
	modport sink (input valid, input data_byte, input bytes_left, output ready);
endinterface

// ===== rtl/utf8x_out_if.sv =====
// output channel: one decoded code point or error status per beat
// depends on utf8x_pkg
`timescale 1ns / 1ps

interface utf8x_out_if;
	logic                             valid;
	logic                             ready;
	logic [utf8x_pkg::CP_BITS-1:0]    code_point;
	logic [3:0]                       status;
	logic [utf8x_pkg::COUNT_BITS-1:0] char_count;
	logic                             string_end;

	modport source (output valid, output code_point, output status, output char_count,
		output string_end, input ready);
	modport sink (input valid, input code_point, input status, input char_count,
		input string_end, output ready);
endinterface

// ===== rtl/utf8x_front.sv =====
// front end: accepts input beats and classifies each byte (lead kind, payload bits,
// whether the rest of the string can finish the form); depends on utf8x_pkg, utf8x_in_if
`timescale 1ns / 1ps

module utf8x_front (
	utf8x_in_if.sink          in_stream,
	input  logic              full,
	output logic              push,
	output utf8x_pkg::cls_t   cls
);

	logic [7:0]                        b;
	logic [utf8x_pkg::LENGTH_BITS-1:0] rest;

	assign in_stream.ready = !full;
	assign push            = in_stream.valid && !full;
	assign b               = in_stream.data_byte;

	always_comb begin
		// zero bytes left counts as the last byte
		rest = (in_stream.bytes_left == '0) ? '0 : in_stream.bytes_left - 1'b1;

		cls.last     = (rest == '0);
		cls.is_cont  = (b[7:6] == 2'b10);
		cls.payload  = b[5:0];
		cls.bad_lead = 1'b0;
		cls.extra    = 3'd0;
		cls.init     = b[6:0];

		case (b) inside
			[8'h00:8'h7f]: begin
				cls.extra = 3'd0;
			end
			[8'hc0:8'hdf]: begin
				cls.extra = 3'd1;
				cls.init  = {2'b00, b[4:0]};
			end
			[8'he0:8'hef]: begin
				cls.extra = 3'd2;
				cls.init  = {3'b000, b[3:0]};
			end
			[8'hf0:8'hf7]: begin
				cls.extra = 3'd3;
				cls.init  = {4'b0000, b[2:0]};
			end
			[8'hf8:8'hfb]: begin
				cls.extra = 3'd4;
				cls.init  = {5'b00000, b[1:0]};
			end
			[8'hfc:8'hfd]: begin
				cls.extra = 3'd5;
				cls.init  = {6'b000000, b[0]};
			end
			8'hfe: begin
				cls.extra = 3'd6;
				cls.init  = '0;
			end
			default: begin
				// stray continuation or 0xff
				cls.bad_lead = 1'b1;
				cls.init     = '0;
			end
		endcase

		cls.incomplete = (utf8x_pkg::LENGTH_BITS'(cls.extra) > rest);
	end

endmodule

// ===== rtl/utf8x_queue.sv =====
// short register queue of classified beats between front and back
// depends on utf8x_pkg
`timescale 1ns / 1ps

module utf8x_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  utf8x_pkg::cls_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output utf8x_pkg::cls_t head_data
);

	localparam logic [utf8x_pkg::QUEUE_PTR_BITS-1:0] LAST_SLOT =
		utf8x_pkg::QUEUE_PTR_BITS'(utf8x_pkg::QUEUE_DEPTH - 1);

	utf8x_pkg::cls_t                         entries_q [utf8x_pkg::QUEUE_DEPTH];
	logic [utf8x_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_q;
	logic [utf8x_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_q;
	logic [utf8x_pkg::QUEUE_CNT_BITS-1:0]    count_q;

	assign full       = (count_q == utf8x_pkg::QUEUE_CNT_BITS'(utf8x_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/utf8x_back.sv =====
// back end: per-string decode state, value checks, character count and output register
// depends on utf8x_pkg, utf8x_out_if
`timescale 1ns / 1ps

module utf8x_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            check_cp,
	input  logic            head_valid,
	input  utf8x_pkg::cls_t head,
	output logic            pop,
	utf8x_out_if.source     out_stream
);

	localparam int AB = utf8x_pkg::ACC_BITS;
	localparam int CB = utf8x_pkg::COUNT_BITS;

	logic [AB-1:0]  acc_q, acc_d;
	logic [2:0]     owed_q, owed_d;
	logic [2:0]     len_q, len_d;
	logic           skip_q, skip_d;
	logic [CB-1:0]  count_q, count_d;

	logic                          out_valid_q;
	logic [utf8x_pkg::CP_BITS-1:0] cp_q;
	utf8x_pkg::status_t            st_q;
	logic [CB-1:0]                 cnt_q;
	logic                          end_q;

	logic [AB-1:0]      acc_shift;
	utf8x_pkg::status_t judge_cont, judge_lead, st;
	logic [AB-1:0]      value;
	logic               emit;
	logic [CB-1:0]      cnt_new;

	function automatic utf8x_pkg::status_t judge(input logic [AB-1:0] v,
		input logic [2:0] len, input logic chk);
		utf8x_pkg::status_t r;
		begin
			r = utf8x_pkg::STATUS_OK;
			if (v < utf8x_pkg::min_for_length(len)) begin
				r = utf8x_pkg::STATUS_OVERLONG;
			end else if (v[AB-1:32] != '0) begin
				r = utf8x_pkg::STATUS_RANGE;
			end else if (chk) begin
				if (v >= AB'(36'hd800) && v <= AB'(36'hdfff)) begin
					r = utf8x_pkg::STATUS_SURROGATE;
				end else if (v == AB'(36'hfffe)) begin
					r = utf8x_pkg::STATUS_FFFE;
				end else if (v == AB'(36'hffff)) begin
					r = utf8x_pkg::STATUS_FFFF;
				end else if (v >= AB'(36'h11_0000)) begin
					r = utf8x_pkg::STATUS_HIGH;
				end
			end
			return r;
		end
	endfunction

	// a beat may leave the queue whenever the output slot is free or draining
	assign pop       = head_valid && (!out_valid_q || out_stream.ready);
	assign acc_shift = {acc_q[AB-7:0], head.payload};
	assign judge_cont = judge(acc_shift, len_q, check_cp);
	assign judge_lead = judge(AB'(head.init), 3'd1, check_cp);

	always_comb begin
		acc_d   = acc_q;
		owed_d  = owed_q;
		len_d   = len_q;
		skip_d  = skip_q;
		count_d = count_q;
		emit    = 1'b0;
		st      = utf8x_pkg::STATUS_OK;
		value   = '0;

		if (pop) begin
			if (skip_q) begin
				if (head.last) begin
					acc_d   = '0;
					owed_d  = '0;
					len_d   = '0;
					skip_d  = 1'b0;
					count_d = '0;
				end
			end else if (owed_q != 3'd0) begin
				if (!head.is_cont) begin
					emit = 1'b1;
					st   = utf8x_pkg::STATUS_BAD_CONT;
				end else begin
					acc_d  = acc_shift;
					owed_d = owed_q - 3'd1;
					if (owed_q == 3'd1) begin
						emit  = 1'b1;
						st    = judge_cont;
						value = acc_shift;
					end else if (head.last) begin
						// string ran out mid-form
						emit = 1'b1;
						st   = utf8x_pkg::STATUS_INCOMPLETE;
					end
				end
			end else if (head.bad_lead) begin
				emit = 1'b1;
				st   = utf8x_pkg::STATUS_BAD_LEAD;
			end else if (head.incomplete) begin
				emit = 1'b1;
				st   = utf8x_pkg::STATUS_INCOMPLETE;
			end else begin
				acc_d  = AB'(head.init);
				len_d  = head.extra + 3'd1;
				owed_d = head.extra;
				if (head.extra == 3'd0) begin
					emit  = 1'b1;
					st    = judge_lead;
					value = AB'(head.init);
				end
			end
		end

		cnt_new = (st == utf8x_pkg::STATUS_OK && count_q != '1) ? count_q + 1'b1 : count_q;

		if (emit) begin
			acc_d  = '0;
			owed_d = '0;
			len_d  = '0;
			if (head.last) begin
				skip_d  = 1'b0;
				count_d = '0;
			end else begin
				count_d = cnt_new;
				if (st != utf8x_pkg::STATUS_OK) begin
					skip_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			owed_q      <= '0;
			len_q       <= '0;
			skip_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			acc_q   <= acc_d;
			owed_q  <= owed_d;
			len_q   <= len_d;
			skip_q  <= skip_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cp_q  <= (st == utf8x_pkg::STATUS_OK) ? value[utf8x_pkg::CP_BITS-1:0] : '0;
			st_q  <= st;
			cnt_q <= cnt_new;
			end_q <= head.last;
		end
	end

	assign out_stream.valid      = out_valid_q;
	assign out_stream.code_point = cp_q;
	assign out_stream.status     = st_q;
	assign out_stream.char_count = cnt_q;
	assign out_stream.string_end = end_q;

endmodule

// ===== rtl/utf8_extended_stream_decoder_top.sv =====
// channel        dir  payload                                        handshake
// in_stream      in   data_byte[7:0], bytes_left[15:0]               valid/ready
// out_stream     out  code_point[31:0], status[3:0], char_count[15:0],
//                     string_end                                     valid/ready
// cfg            in   cfg_wdata = check_code_points                  cfg_we, no wait
//
// one byte is taken every cycle while the queue is not full; a byte's result is registered
// first in the queue stage and then in the decode/output register stage
// reset clears the decode state and the queue and sets check_code_points to 1
// a stalled output holds its beat; the two-entry queue absorbs bytes, then ready drops
// depends on utf8x_pkg, utf8x_in_if, utf8x_out_if, utf8x_front, utf8x_queue, utf8x_back
`timescale 1ns / 1ps

module utf8_extended_stream_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	utf8x_in_if.sink    in_stream,
	utf8x_out_if.source out_stream,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	logic            check_cp_q;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;
	utf8x_pkg::cls_t cls;
	utf8x_pkg::cls_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_cp_q <= 1'b1;
		end else if (cfg_we) begin
			check_cp_q <= cfg_wdata;
		end
	end

	utf8x_front u_front (
		.in_stream (in_stream),
		.full      (full),
		.push      (push),
		.cls       (cls)
	);

	utf8x_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (cls),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_data  (head)
	);

	utf8x_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.check_cp   (check_cp_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_stream (out_stream)
	);

	// an error beat never carries a value
	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_stream.valid && out_stream.status != utf8x_pkg::STATUS_OK
		|-> out_stream.code_point == '0)
		else $error("error beat with nonzero code point");

	// a decoded character is always counted
	a_ok_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_stream.valid && out_stream.status == utf8x_pkg::STATUS_OK
		|-> out_stream.char_count != '0)
		else $error("ok beat with zero character count");

	// with checks on, only scalar values below 0x110000 pass
	a_checked_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_stream.valid && out_stream.status == utf8x_pkg::STATUS_OK && check_cp_q
		|-> out_stream.code_point < 32'h0011_0000
			&& (out_stream.code_point < 32'h0000_d800 || out_stream.code_point > 32'h0000_dfff))
		else $error("checked code point out of range");

	// nothing is taken from the queue while it is empty
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// ===== verif/tb_top.sv =====
// self-checking bench for the extended utf-8 stream decoder: directed table, then random strings
// byte-level decoder predictor, random idling on both channels, long receiver hold
// depends on utf8x_pkg, utf8x_in_if, utf8x_out_if and utf8_extended_stream_decoder_top
`timescale 1ns / 1ps

module tb_top;
	import utf8x_pkg::*;

	localparam int HALF_PERIOD    = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int QUIET_LIMIT    = 5000;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_BYTES    = 250;

	typedef struct packed {
		logic [CP_BITS-1:0]    code_point;
		status_t               status;
		logic [COUNT_BITS-1:0] char_count;
		logic                  string_end;
	} decoded_t;

	typedef struct {
		logic [7:0]             data_byte;
		logic [LENGTH_BITS-1:0] bytes_left;
		bit                     typed;
		decoded_t               result;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	utf8x_in_if  in_if();
	utf8x_out_if out_if();

	utf8_extended_stream_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_stream(in_if),
		.out_stream(out_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// decoder state as the predictor sees it
	logic [ACC_BITS-1:0]   acc_value;
	logic [2:0]            owed_bytes;
	logic [2:0]            form_bytes;
	bit                    skip_string;
	logic [COUNT_BITS-1:0] chars_decoded;
	bit                    check_cp;

	decoded_t pending_results[$];
	logic [7:0] string_bytes[$];
	row_t directed_rows[25];

	// the directed row in flight travels with the beat
	bit       row_typed;
	decoded_t row_result;

	int send_idle_pct;
	int rcv_idle_pct;
	int hold_requests;
	int bytes_sent;
	int results_checked;
	int failures;
	logic [15:0] statuses_seen;

	logic [31:0] notable_values[18] = '{
		32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hd7ff, 32'hd800, 32'hdfff, 32'he000,
		32'hfffd, 32'hfffe, 32'hffff, 32'h10000, 32'h10ffff, 32'h110000, 32'h7fffffff,
		32'h80000000, 32'hffffffff
	};

	function automatic void clear_string();
		acc_value = '0;
		owed_bytes = '0;
		form_bytes = '0;
		skip_string = 1'b0;
		chars_decoded = '0;
	endfunction

	function automatic status_t judge_value(logic [ACC_BITS-1:0] v, logic [2:0] len);
		logic [ACC_BITS-1:0] floor_val;
		case (len)
			3'd2: floor_val = 36'h80;
			3'd3: floor_val = 36'h800;
			3'd4: floor_val = 36'h10000;
			3'd5: floor_val = 36'h200000;
			3'd6: floor_val = 36'h4000000;
			3'd7: floor_val = 36'h80000000;
			default: floor_val = '0;
		endcase
		if (v < floor_val)
			return STATUS_OVERLONG;
		if (v >= 36'h1_0000_0000)
			return STATUS_RANGE;
		if (check_cp) begin
			if (v >= 36'hd800 && v <= 36'hdfff)
				return STATUS_SURROGATE;
			if (v == 36'hfffe)
				return STATUS_FFFE;
			if (v == 36'hffff)
				return STATUS_FFFF;
			if (v >= 36'h110000)
				return STATUS_HIGH;
		end
		return STATUS_OK;
	endfunction

	function automatic decoded_t emit_result(logic [CP_BITS-1:0] cp, status_t st, bit is_end);
		decoded_t r;
		if (st == STATUS_OK && chars_decoded != '1)
			chars_decoded++;
		r.code_point = cp;
		r.status = st;
		r.char_count = chars_decoded;
		r.string_end = is_end;
		acc_value = '0;
		owed_bytes = '0;
		form_bytes = '0;
		if (is_end)
			clear_string();
		else if (st != STATUS_OK)
			skip_string = 1'b1;
		return r;
	endfunction

	function automatic decoded_t finish_char(bit is_end);
		status_t st;
		st = judge_value(acc_value, form_bytes);
		return emit_result((st == STATUS_OK) ? acc_value[CP_BITS-1:0] : '0, st, is_end);
	endfunction

	// returns 1 when the byte produces a result
	function automatic bit decode_byte(input logic [7:0] b, input logic [LENGTH_BITS-1:0] left,
			output decoded_t r);
		logic [LENGTH_BITS-1:0] rest;
		bit is_end;
		bit bad_lead;
		logic [2:0] extra;
		logic [6:0] init;
		rest = (left == 0) ? '0 : left - 1'b1;
		is_end = (rest == 0);
		bad_lead = 1'b0;
		extra = '0;
		init = '0;
		r = '0;
		if (skip_string) begin
			if (is_end)
				clear_string();
			return 1'b0;
		end
		if (owed_bytes != 0) begin
			if (b[7:6] != 2'b10) begin
				r = emit_result('0, STATUS_BAD_CONT, is_end);
				return 1'b1;
			end
			acc_value = {acc_value[ACC_BITS-7:0], b[5:0]};
			owed_bytes--;
			if (owed_bytes == 0) begin
				r = finish_char(is_end);
				return 1'b1;
			end
			if (is_end) begin
				// string ran out although the lead looked complete
				r = emit_result('0, STATUS_INCOMPLETE, 1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		casez (b)
			8'b0???????: init = b[6:0];
			8'b110?????: begin
				extra = 3'd1;
				init = {2'b00, b[4:0]};
			end
			8'b1110????: begin
				extra = 3'd2;
				init = {3'b000, b[3:0]};
			end
			8'b11110???: begin
				extra = 3'd3;
				init = {4'b0000, b[2:0]};
			end
			8'b111110??: begin
				extra = 3'd4;
				init = {5'b00000, b[1:0]};
			end
			8'b1111110?: begin
				extra = 3'd5;
				init = {6'b000000, b[0]};
			end
			8'hfe: extra = 3'd6;
			default: bad_lead = 1'b1;
		endcase
		if (bad_lead) begin
			r = emit_result('0, STATUS_BAD_LEAD, is_end);
			return 1'b1;
		end
		if (extra > rest) begin
			r = emit_result('0, STATUS_INCOMPLETE, is_end);
			return 1'b1;
		end
		acc_value = ACC_BITS'(init);
		form_bytes = extra + 3'd1;
		owed_bytes = extra;
		if (extra == 0) begin
			r = finish_char(is_end);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic row_t typed_row(logic [7:0] b, logic [LENGTH_BITS-1:0] left,
			logic [CP_BITS-1:0] cp, status_t st, logic [COUNT_BITS-1:0] cnt, bit is_end);
		row_t r;
		r.data_byte = b;
		r.bytes_left = left;
		r.typed = 1'b1;
		r.result.code_point = cp;
		r.result.status = st;
		r.result.char_count = cnt;
		r.result.string_end = is_end;
		return r;
	endfunction

	function automatic row_t plain_row(logic [7:0] b, logic [LENGTH_BITS-1:0] left);
		row_t r;
		r.data_byte = b;
		r.bytes_left = left;
		r.typed = 1'b0;
		r.result = '0;
		return r;
	endfunction

	function automatic int canon_len(logic [ACC_BITS-1:0] v);
		if (v < 36'h80) return 1;
		if (v < 36'h800) return 2;
		if (v < 36'h10000) return 3;
		if (v < 36'h200000) return 4;
		if (v < 36'h4000000) return 5;
		if (v < 36'h80000000) return 6;
		return 7;
	endfunction

	function automatic logic [ACC_BITS-1:0] draw_value(int len);
		case (len)
			1: return ACC_BITS'($urandom_range(32'h7f, 32'h0));
			2: return ACC_BITS'($urandom_range(32'h7ff, 32'h80));
			3: return ACC_BITS'($urandom_range(32'hffff, 32'h800));
			4: return ACC_BITS'($urandom_range(32'h1fffff, 32'h10000));
			5: return ACC_BITS'($urandom_range(32'h3ffffff, 32'h200000));
			6: return ACC_BITS'($urandom_range(32'h7fffffff, 32'h4000000));
			default: return ACC_BITS'($urandom_range(32'hffffffff, 32'h80000000));
		endcase
	endfunction

	// encodes v as a form of len bytes, overlong when len exceeds what v needs
	function automatic void append_char(logic [ACC_BITS-1:0] v, int len);
		logic [7:0] lead_mark;
		case (len)
			2: lead_mark = 8'hc0;
			3: lead_mark = 8'he0;
			4: lead_mark = 8'hf0;
			5: lead_mark = 8'hf8;
			6: lead_mark = 8'hfc;
			7: lead_mark = 8'hfe;
			default: lead_mark = 8'h00;
		endcase
		string_bytes.push_back(lead_mark | 8'(v >> (6 * (len - 1))));
		for (int k = len - 2; k >= 0; k--)
			string_bytes.push_back(8'h80 | (8'(v >> (6 * k)) & 8'h3f));
	endfunction

	function automatic void add_random_char();
		int kind;
		int len;
		int pos;
		int cut;
		logic [ACC_BITS-1:0] v;
		logic [7:0] junk;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			len = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 7);
			append_char(draw_value(len), len);
		end else if (kind < 65) begin
			v = 36'(notable_values[$urandom_range(0, 17)]);
			if ($urandom_range(0, 3) == 0)
				v = ACC_BITS'($urandom_range(32'hdfff, 32'hd800));
			append_char(v, canon_len(v));
		end else if (kind < 75) begin
			len = $urandom_range(2, 7);
			append_char(draw_value($urandom_range(1, len - 1)), len);
		end else if (kind < 82) begin
			// 0xfe form carrying 2^32 or more
			v = {6'($urandom_range(63, 4)), 30'($urandom)};
			append_char(v, 7);
		end else if (kind < 88) begin
			string_bytes.push_back($urandom_range(0, 1) ? 8'hff : 8'($urandom_range(8'hbf, 8'h80)));
		end else if (kind < 94) begin
			len = $urandom_range(2, 7);
			pos = string_bytes.size() + $urandom_range(1, len - 1);
			append_char(draw_value(len), len);
			junk = 8'($urandom);
			if (junk[7:6] == 2'b10)
				junk[6] = 1'b1;
			string_bytes[pos] = junk;
		end else begin
			len = $urandom_range(2, 7);
			cut = $urandom_range(1, len - 1);
			append_char(draw_value(len), len);
			repeat (cut) void'(string_bytes.pop_back());
		end
	endfunction

	task automatic send_byte(logic [7:0] b, logic [LENGTH_BITS-1:0] left, bit typed,
			decoded_t result);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data_byte <= b;
		in_if.bytes_left <= left;
		row_typed <= typed;
		row_result <= result;
		do
			@(posedge clk);
		while (!in_if.ready);
		bytes_sent++;
	endtask

	task automatic send_string();
		int n;
		int pad;
		bit zero_end;
		logic [LENGTH_BITS-1:0] left;
		n = string_bytes.size();
		// padded counts let a form pass the lead check and then run out
		pad = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 6) : 0;
		zero_end = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < n; i++) begin
			if (i == n - 1)
				left = zero_end ? '0 : LENGTH_BITS'(1);
			else
				left = LENGTH_BITS'(n - i + pad);
			send_byte(string_bytes[i], left, 1'b0, '0);
		end
		string_bytes.delete();
	endtask

	task automatic random_phase(int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			if ($urandom_range(0, 99) < 10) begin
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom), LENGTH_BITS'($urandom), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 6)) add_random_char();
				send_string();
			end
		end
	endtask

	// register writes only once the pipeline has drained
	task automatic write_check(bit value);
		in_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		check_cp = value;
	endtask

	task automatic compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
			failures++;
		end
	endtask

	// receiver: random ready, with a long hold on request
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		decoded_t predicted;
		decoded_t want;
		bit has_result;
		if (arst_n) begin
			if (in_if.valid && in_if.ready) begin
				has_result = decode_byte(in_if.data_byte, in_if.bytes_left, predicted);
				if (row_typed)
					pending_results.push_back(row_result);
				else if (has_result)
					pending_results.push_back(predicted);
			end
			if (out_if.valid && out_if.ready) begin
				results_checked++;
				statuses_seen[out_if.status] = 1'b1;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual cp %h status %0d count %0d end %0b",
						$time, out_if.code_point, out_if.status, out_if.char_count,
						out_if.string_end);
					failures++;
				end else begin
					want = pending_results.pop_front();
					compare_field("code_point", want.code_point, out_if.code_point);
					compare_field("status", 32'(want.status), 32'(out_if.status));
					compare_field("char_count", 32'(want.char_count), 32'(out_if.char_count));
					compare_field("string_end", 32'(want.string_end), 32'(out_if.string_end));
				end
			end
		end
	end

	always @(posedge clk) begin
		int quiet_cycles;
		if (!arst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: watchdog: %0d cycles without a beat, %0d results outstanding",
				$time, quiet_cycles, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_if.valid = 1'b0;
		in_if.data_byte = '0;
		in_if.bytes_left = LENGTH_BITS'(1);
		out_if.ready = 1'b0;
		row_typed = 1'b0;
		row_result = '0;
		hold_requests = 0;
		bytes_sent = 0;
		results_checked = 0;
		failures = 0;
		statuses_seen = '0;
		check_cp = 1'b1;
		clear_string();
		send_idle_pct = 25;
		rcv_idle_pct = 67;

		directed_rows = '{
			typed_row(8'h00, 1, 32'h0, STATUS_OK, 1, 1'b1),
			typed_row(8'h7f, 0, 32'h7f, STATUS_OK, 1, 1'b1),     // zero bytes left ends the string
			typed_row(8'hff, 2, 32'h0, STATUS_BAD_LEAD, 0, 1'b0),
			plain_row(8'h41, 1),                                   // skipped, clears the string
			typed_row(8'hc3, 1, 32'h0, STATUS_INCOMPLETE, 0, 1'b1),
			plain_row(8'he2, 5),
			typed_row(8'h82, 1, 32'h0, STATUS_INCOMPLETE, 0, 1'b1), // ends mid-form
			plain_row(8'hc0, 2),
			typed_row(8'h80, 1, 32'h0, STATUS_OVERLONG, 0, 1'b1),
			plain_row(8'he2, 3),
			typed_row(8'h41, 2, 32'h0, STATUS_BAD_CONT, 0, 1'b0),
			plain_row(8'h00, 1),
			plain_row(8'hed, 3),
			plain_row(8'ha0, 2),
			typed_row(8'h80, 1, 32'h0, STATUS_SURROGATE, 0, 1'b1),
			plain_row(8'hef, 3),
			plain_row(8'hbf, 2),
			typed_row(8'hbe, 1, 32'h0, STATUS_FFFE, 0, 1'b1),
			plain_row(8'hfe, 7),
			plain_row(8'h84, 6),
			plain_row(8'h80, 5),
			plain_row(8'h80, 4),
			plain_row(8'h80, 3),
			plain_row(8'h80, 2),
			typed_row(8'h80, 1, 32'h0, STATUS_RANGE, 0, 1'b1)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		write_check(1'b1);
		foreach (directed_rows[i])
			send_byte(directed_rows[i].data_byte, directed_rows[i].bytes_left,
				directed_rows[i].typed, directed_rows[i].result);

		write_check(1'b0);
		random_phase(PHASE_BYTES);

		send_idle_pct = 67;
		rcv_idle_pct = 25;
		write_check(1'b1);
		random_phase(PHASE_BYTES);

		send_idle_pct = 0;
		rcv_idle_pct = 0;
		write_check(1'b0);
		// receiver stalls while bytes keep coming, so the input backs up
		hold_requests++;
		random_phase(PHASE_BYTES);

		in_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES * 2) @(posedge clk);

		$display("run: %0d bytes in, %0d results checked, %0d failures",
			bytes_sent, results_checked, failures);
		$display("statuses seen %b, code point checks on and off, receiver hold of %0d cycles",
			statuses_seen[9:0], HOLD_CYCLES);
		if (failures == 0 && pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== utf8_extended_stream_decoder_top.f =====
rtl/utf8x_pkg.sv
rtl/utf8x_in_if.sv
rtl/utf8x_out_if.sv
rtl/utf8x_front.sv
rtl/utf8x_queue.sv
rtl/utf8x_back.sv
rtl/utf8_extended_stream_decoder_top.sv
verif/tb_top.sv
